[hdl/lpp_pkg.sv]
// Package for lidar point projection: types, constants, CORDIC angle table.
// No dependencies.
package lpp_pkg;
  localparam int unsigned TWO_PI_URAD = 6283185;
  localparam int unsigned PI_URAD_FLOOR = 3141592;
  localparam int unsigned TWO_PI_H = 12566371;
  localparam int unsigned PI_H = 6283185;
  localparam int unsigned HALF_PI_H = 3141593;
  localparam int unsigned CORDIC_STEPS = 18;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic signed [17:0] ONE_Q16 = 18'sd65536;

  localparam logic [2:0] REG_LROW0 = 3'd0;
  localparam logic [2:0] REG_LROW1 = 3'd1;
  localparam logic [2:0] REG_LROW2 = 3'd2;
  localparam logic [2:0] REG_CROW0 = 3'd3;
  localparam logic [2:0] REG_CROW1 = 3'd4;
  localparam logic [2:0] REG_CROW2 = 3'd5;
  localparam logic [2:0] REG_LOFF = 3'd6;
  localparam logic [2:0] REG_COFF = 3'd7;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_POINT = 1'b1;

  typedef struct packed {
    logic [19:0] range_mm;
    logic [31:0] intensity;
    logic signed [24:0] mirror_h;
    logic signed [25:0] spindle_h;
    logic last_point;
  } job_t;

  function automatic logic signed [24:0] atan_h(input logic [4:0] i);
    logic signed [24:0] v;
    unique case (i)
      5'd0: v = 25'sd1570796;
      5'd1: v = 25'sd927295;
      5'd2: v = 25'sd489957;
      5'd3: v = 25'sd248710;
      5'd4: v = 25'sd124838;
      5'd5: v = 25'sd62480;
      5'd6: v = 25'sd31247;
      5'd7: v = 25'sd15625;
      5'd8: v = 25'sd7812;
      5'd9: v = 25'sd3906;
      5'd10: v = 25'sd1953;
      5'd11: v = 25'sd977;
      5'd12: v = 25'sd488;
      5'd13: v = 25'sd244;
      5'd14: v = 25'sd122;
      5'd15: v = 25'sd61;
      5'd16: v = 25'sd31;
      5'd17: v = 25'sd15;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

  // round half away from zero, shift by s
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int s);
    logic [63:0] mag;
    logic [63:0] half;
    half = 64'd1 << (s - 1);
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + half) >> s;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else return v[31:0];
  endfunction
endpackage

[hdl/lpp_if.sv]
// Valid/ready stream interfaces for the projection block.
// Depends on nothing.
interface lpp_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [22:0] scan_arc_urad;
  logic [22:0] start_angle_urad;
  logic [22:0] end_angle_urad;
  logic [11:0] point_total;
  logic [19:0] range_mm;
  logic [31:0] intensity_in;
  modport source(output valid, op, scan_arc_urad, start_angle_urad, end_angle_urad,
                 point_total, range_mm, intensity_in, input ready);
  modport sink(input valid, op, scan_arc_urad, start_angle_urad, end_angle_urad,
               point_total, range_mm, intensity_in, output ready);
endinterface

interface lpp_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] x_um;
  logic signed [31:0] y_um;
  logic signed [31:0] z_um;
  logic [31:0] intensity_out;
  logic last_point;
  modport source(output valid, x_um, y_um, z_um, intensity_out, last_point,
                 input ready);
  modport sink(input valid, x_um, y_um, z_um, intensity_out, last_point,
               output ready);
endinterface

[hdl/lpp_front.sv]
// Front end: header latching, reciprocal divider, angle interpolation.
// Depends on lpp_pkg and lpp_in_if. Emits jobs into a short queue.
module lpp_front import lpp_pkg::*; #(
  parameter int MAX_POINTS = 2048
) (
  input  logic clk,
  input  logic rst,
  lpp_in_if.sink in_ch,
  output logic job_valid,
  input  logic job_ready,
  output job_t job
);
  typedef enum logic [4:0] {
    F_IDLE = 5'b00001, F_NORM = 5'b00010, F_DIV = 5'b00100,
    F_MUL = 5'b01000, F_EMIT = 5'b10000
  } fstate_t;
  fstate_t state;

  logic [11:0] point_index, points_in_scan;
  logic [22:0] arc_width;
  logic signed [23:0] spindle_start, spindle_span;
  logic [31:0] index_reciprocal;

  logic [22:0] h_start, h_end;
  logic [11:0] h_cnt;
  logic [19:0] range_r;
  logic [31:0] inten_r;
  logic [43:0] frac;
  logic [5:0] dcnt;
  logic [32:0] rem;
  logic [31:0] quo;
  logic [11:0] den;
  logic [11:0] cnt_clamp;
  logic signed [23:0] sn, en, sp;
  logic signed [63:0] m2, s2;

  function automatic logic signed [23:0] norm(input logic signed [24:0] a);
    logic signed [25:0] m;
    m = 26'(a);
    if (m > 26'sd3141592 * 2 + 26'sd1) m = m - 26'sd6283185;
    if (m > 26'sd3141592) m = m - 26'sd6283185;
    if (m < -26'sd3141592) m = m + 26'sd6283185;
    return m[23:0];
  endfunction

  always_comb begin
    cnt_clamp = ({20'd0, in_ch.point_total} > 32'(MAX_POINTS)) ? 12'(MAX_POINTS)
                                                                : in_ch.point_total;
    sn = norm(25'(h_start));
    en = norm(25'(h_end));
    sp = norm(25'(en) - 25'(sn));
    m2 = rnd_shift(64'(frac) * 64'(2 * arc_width), 31) - 64'(arc_width);
    s2 = 64'(2 * spindle_start) +
         rnd_shift($signed(64'(frac)) * 64'(2 * spindle_span), 31);
  end

  assign in_ch.ready = (state == F_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      point_index <= '0;
      points_in_scan <= '0;
      arc_width <= '0;
      spindle_start <= '0;
      spindle_span <= '0;
      index_reciprocal <= '0;
      job_valid <= 1'b0;
    end else begin
      unique case (state)
        F_IDLE: if (in_ch.valid) begin
          if (in_ch.op == OP_HEADER) begin
            arc_width <= in_ch.scan_arc_urad;
            h_start <= in_ch.start_angle_urad;
            h_end <= in_ch.end_angle_urad;
            h_cnt <= cnt_clamp;
            points_in_scan <= cnt_clamp;
            point_index <= '0;
            state <= F_NORM;
          end else if (point_index < points_in_scan) begin
            range_r <= in_ch.range_mm;
            inten_r <= in_ch.intensity_in;
            frac <= 44'(point_index) * 44'(index_reciprocal);
            state <= F_MUL;
          end
        end
        F_NORM: begin
          spindle_start <= sn;
          spindle_span <= sp;
          den <= h_cnt - 12'd1;
          rem <= 33'(32'h80000000 + 32'((h_cnt - 12'd1) >> 1));
          quo <= '0;
          dcnt <= 6'd33;
          if (h_cnt < 12'd2) begin
            index_reciprocal <= '0;
            state <= F_IDLE;
          end else state <= F_DIV;
        end
        F_DIV: begin
          // restoring division, one quotient bit per cycle
          if (dcnt == 6'd0) begin
            index_reciprocal <= quo;
            state <= F_IDLE;
          end else begin
            dcnt <= dcnt - 6'd1;
            if ((rem >> (dcnt - 6'd1)) >= 33'(den)) begin
              rem <= rem - (33'(den) << (dcnt - 6'd1));
              quo <= quo | (32'd1 << (dcnt - 6'd1));
            end
          end
        end
        F_MUL: begin
          job.range_mm <= range_r;
          job.intensity <= inten_r;
          job.mirror_h <= m2[24:0];
          job.spindle_h <= s2[25:0];
          job.last_point <= (point_index + 12'd1 == points_in_scan);
          point_index <= point_index + 12'd1;
          job_valid <= 1'b1;
          state <= F_EMIT;
        end
        F_EMIT: if (job_ready) begin
          job_valid <= 1'b0;
          state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

[hdl/lpp_back.sv]
// Back end: shared iterative CORDIC and sequential rotation/translation stages.
// Depends on lpp_pkg and lpp_out_if; consumes jobs from the queue.
module lpp_back import lpp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  input  logic [53:0] lrow [3],
  input  logic [53:0] crow [3],
  input  logic [62:0] loff,
  input  logic [62:0] coff,
  lpp_out_if.source out_ch
);
  typedef enum logic [5:0] {
    B_IDLE = 6'b000001, B_FOLD = 6'b000010, B_ITER = 6'b000100,
    B_POST = 6'b001000, B_XFM = 6'b010000, B_OUT = 6'b100000
  } bstate_t;
  bstate_t state;

  job_t jr;
  logic which;
  logic signed [25:0] ang;
  logic neg;
  logic signed [33:0] cx, cy;
  logic [4:0] it;
  logic signed [17:0] ms, mc, ss, sc;
  logic [3:0] step;
  logic signed [63:0] v [3];
  logic [1:0] rsel;
  logic signed [63:0] res [3];

  logic signed [26:0] a_w, a_f;
  logic fneg;
  logic signed [63:0] rx, ry;
  logic signed [17:0] qx, qy;

  function automatic logic signed [17:0] ent(input logic [53:0] row, input logic [1:0] j);
    unique case (j)
      2'd0: return row[53:36];
      2'd1: return row[35:18];
      default: return row[17:0];
    endcase
  endfunction

  function automatic logic signed [63:0] offv(input logic [62:0] o, input logic [1:0] r);
    logic signed [20:0] t;
    unique case (r)
      2'd0: t = o[62:42];
      2'd1: t = o[41:21];
      default: t = o[20:0];
    endcase
    return 64'(t) * 64'sd10;
  endfunction

  always_comb begin
    a_w = 27'(ang);
    if (a_w < 0) a_w = a_w + 27'sd12566371;
    if (a_w < 0) a_w = a_w + 27'sd12566371;
    if (a_w >= 27'sd12566371) a_w = a_w - 27'sd12566371;
    if (a_w > 27'sd6283185) a_w = a_w - 27'sd12566371;
    fneg = 1'b0;
    a_f = a_w;
    if (a_w > 27'sd3141593) begin
      a_f = a_w - 27'sd6283185; fneg = 1'b1;
    end else if (a_w < -27'sd3141593) begin
      a_f = a_w + 27'sd6283185; fneg = 1'b1;
    end
    rx = rnd_shift(64'(cx), 14);
    ry = rnd_shift(64'(cy), 14);
    if (rx > 64'(ONE_Q16)) rx = 64'(ONE_Q16);
    if (rx < -64'(ONE_Q16)) rx = -64'(ONE_Q16);
    if (ry > 64'(ONE_Q16)) ry = 64'(ONE_Q16);
    if (ry < -64'(ONE_Q16)) ry = -64'(ONE_Q16);
    qx = neg ? -rx[17:0] : rx[17:0];
    qy = neg ? -ry[17:0] : ry[17:0];
  end

  assign job_ready = (state == B_IDLE);
  assign out_ch.valid = (state == B_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      unique case (state)
        B_IDLE: if (job_valid) begin
          jr <= job;
          which <= 1'b0;
          ang <= 26'(job.mirror_h);
          state <= B_FOLD;
        end
        B_FOLD: begin
          ang <= a_f[25:0];
          neg <= fneg;
          cx <= CORDIC_GAIN_Q30;
          cy <= '0;
          it <= '0;
          state <= B_ITER;
        end
        B_ITER: begin
          if (ang >= 0) begin
            cx <= cx - (cy >>> it);
            cy <= cy + (cx >>> it);
            ang <= ang - 26'(atan_h(it));
          end else begin
            cx <= cx + (cy >>> it);
            cy <= cy - (cx >>> it);
            ang <= ang + 26'(atan_h(it));
          end
          it <= it + 5'd1;
          if (it == 5'(CORDIC_STEPS - 1)) state <= B_POST;
        end
        B_POST: begin
          if (!which) begin
            mc <= qx; ms <= qy;
            which <= 1'b1;
            ang <= jr.spindle_h;
            state <= B_FOLD;
          end else begin
            sc <= qx; ss <= qy;
            step <= '0;
            state <= B_XFM;
          end
        end
        B_XFM: begin
          // products and rounds in sequence, selected by step
          step <= step + 4'd1;
          unique case (step)
            4'd0: v[0] <= rnd_shift(64'(jr.range_mm) * 64'sd1000 * 64'(ms), 16);
            4'd1: begin
              v[2] <= rnd_shift(64'(jr.range_mm) * 64'sd1000 * 64'(mc), 16);
              v[1] <= '0; rsel <= 2'd0;
            end
            4'd2, 4'd3, 4'd4: begin
              res[rsel] <= rnd_shift(64'(ent(lrow[rsel], 2'd0)) * v[0] +
                64'(ent(lrow[rsel], 2'd1)) * v[1] +
                64'(ent(lrow[rsel], 2'd2)) * v[2], 16) + offv(loff, rsel);
              rsel <= (rsel == 2'd2) ? 2'd0 : rsel + 2'd1;
            end
            4'd5: begin
              v[0] <= rnd_shift(64'(sc) * res[0] - 64'(ss) * res[1], 16);
              v[1] <= rnd_shift(64'(ss) * res[0] + 64'(sc) * res[1], 16);
              v[2] <= res[2];
            end
            4'd6, 4'd7, 4'd8: begin
              res[rsel] <= rnd_shift(64'(ent(crow[rsel], 2'd0)) * v[0] +
                64'(ent(crow[rsel], 2'd1)) * v[1] +
                64'(ent(crow[rsel], 2'd2)) * v[2], 16) + offv(coff, rsel);
              rsel <= (rsel == 2'd2) ? 2'd0 : rsel + 2'd1;
              if (step == 4'd8) state <= B_OUT;
            end
            default: ;
          endcase
        end
        B_OUT: if (out_ch.ready) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  assign out_ch.x_um = sat32(res[0]);
  assign out_ch.y_um = sat32(res[1]);
  assign out_ch.z_um = sat32(res[2]);
  assign out_ch.intensity_out = jr.intensity;
  assign out_ch.last_point = jr.last_point;
endmodule

[hdl/lidar_point_projection.sv]
// Top level of the lidar point projection block.
// Depends on lpp_pkg, lpp_if, lpp_front, lpp_back.
//
// Usage: in_ch carries header items (op 0) and point items (op 1); out_ch
// carries projected points in micrometres with intensity and last flag.
// A header with two or more points runs the reciprocal divider, one bit a cycle.
// A point is latched, interpolated and emitted by the front, then the back
// runs two 18-step CORDIC passes on one shared unit plus 9 transform steps.
// The two-entry queue lets the front interpolate the next point while the
// back computes. Points beyond the scan count are dropped silently.
// Reset clears scan state, restores identity rotations and zero offsets.
// When the receiver stalls, the back holds its result and the queue fills,
// then in_ch.ready drops. Config writes via APB, 8-byte register stride.
module lidar_point_projection import lpp_pkg::*; #(
  parameter int MAX_POINTS = 2048
) (
  input  logic clk,
  input  logic rst,
  lpp_in_if.sink in_ch,
  lpp_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [5:0] paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic pready
);
  logic [53:0] lrow [3];
  logic [53:0] crow [3];
  logic [62:0] loff, coff;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx = paddr[5:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      lrow[0] <= 54'(ONE_Q16) << 36; lrow[1] <= 54'(ONE_Q16) << 18;
      lrow[2] <= 54'(ONE_Q16);
      crow[0] <= 54'(ONE_Q16) << 36; crow[1] <= 54'(ONE_Q16) << 18;
      crow[2] <= 54'(ONE_Q16);
      loff <= '0; coff <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_LROW0: lrow[0] <= pwdata[53:0];
        REG_LROW1: lrow[1] <= pwdata[53:0];
        REG_LROW2: lrow[2] <= pwdata[53:0];
        REG_CROW0: crow[0] <= pwdata[53:0];
        REG_CROW1: crow[1] <= pwdata[53:0];
        REG_CROW2: crow[2] <= pwdata[53:0];
        REG_LOFF: loff <= pwdata[62:0];
        REG_COFF: coff <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_LROW0: prdata = 64'(lrow[0]);
      REG_LROW1: prdata = 64'(lrow[1]);
      REG_LROW2: prdata = 64'(lrow[2]);
      REG_CROW0: prdata = 64'(crow[0]);
      REG_CROW1: prdata = 64'(crow[1]);
      REG_CROW2: prdata = 64'(crow[2]);
      REG_LOFF: prdata = 64'(loff);
      REG_COFF: prdata = 64'(coff);
      default: prdata = '0;
    endcase
  end

  logic f_valid, f_ready;
  job_t f_job;
  job_t q [2];
  logic [1:0] q_cnt;
  logic q_wp, q_rp;
  logic q_push, q_pop, b_ready;

  lpp_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job));

  assign f_ready = (q_cnt != 2'd2);
  assign q_push = f_valid && f_ready;
  assign q_pop = (q_cnt != 2'd0) && b_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0; q_wp <= 1'b0; q_rp <= 1'b0;
    end else begin
      if (q_push) begin
        q[q_wp] <= f_job; q_wp <= ~q_wp;
      end
      if (q_pop) q_rp <= ~q_rp;
      q_cnt <= q_cnt + 2'(q_push) - 2'(q_pop);
    end
  end

  lpp_back u_back (
    .clk(clk), .rst(rst), .job_valid(q_cnt != 2'd0), .job_ready(b_ready),
    .job(q[q_rp]), .lrow(lrow), .crow(crow), .loff(loff), .coff(coff),
    .out_ch(out_ch));

  a_qbound: assert property (@(posedge clk) disable iff (rst) q_cnt <= 2'd2)
    else $error("queue overflow");
  a_qpop: assert property (@(posedge clk) disable iff (rst)
    (q_cnt == 2'd0) |-> !q_pop) else $error("pop from empty queue");
  a_qinc: assert property (@(posedge clk) disable iff (rst)
    (q_push && !q_pop) |=> (q_cnt == $past(q_cnt) + 2'd1))
    else $error("queue count slip");
endmodule
